>>> rtl/rps_pkg.sv
// shared constants, types and the divider step for the permutation shuffler
`default_nettype none
package rps_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int DIV_WIDTH   = IDX_WIDTH + 1;
   localparam int COUNT_WIDTH = 7;
   localparam int WORD_WIDTH  = 31;
   localparam int DIV_BITS    = 2;
   localparam int SHIFT_WIDTH = 32;
   localparam int DIV_STEPS   = SHIFT_WIDTH / DIV_BITS;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(TABLE_DEPTH);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DRAW  = 1'b1;

   typedef logic [IDX_WIDTH-1:0] idx_type;

   typedef struct packed {
      logic    clear;
      logic    rd_en;
      idx_type rd_addr_a;
      idx_type rd_addr_b;
      logic    wr_en;
      idx_type wr_addr;
      idx_type wr_data;
   } tbl_req_type;

   // one restoring step: shift in a dividend bit, subtract when it fits
   function automatic logic [DIV_WIDTH-1:0] mod_step(
      input logic [DIV_WIDTH-1:0] rem,
      input logic                 din,
      input logic [DIV_WIDTH-1:0] divisor
   );
      logic [DIV_WIDTH-1:0] t;
      t = {rem[DIV_WIDTH-2:0], din};
      if (t >= divisor) begin
         mod_step = t - divisor;
      end else begin
         mod_step = t;
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/rps_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none
interface rps_req_if;
   import rps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [WORD_WIDTH-1:0] random_word;
   modport source (output valid, output req_type, output random_word, input ready);
   modport sink (input valid, input req_type, input random_word, output ready);
endinterface

interface rps_rsp_if;
   import rps_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [IDX_WIDTH-1:0] slot;
   logic [IDX_WIDTH-1:0] value;
   logic                 last;
   modport source (output valid, output slot, output value, output last, input ready);
   modport sink (input valid, input slot, input value, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/random_permutation_shuffler_top.sv
// draw: the remainder unit runs, then a table read, two swap writes, and the result is loaded with the second
// the 2-bit-per-cycle remainder loop sets the rate; a final draw adds a read and result for entry 0
// start: handled in idle; a count of one gives its result in the next cycle
// one item at a time: req ready only while idle with the result register empty
// synchronous reset: idle, count 64, table reads back as the identity
`default_nettype none
module random_permutation_shuffler_top (
   input  wire                                clock,
   input  wire                                reset,
   rps_req_if.sink                            req_chan,
   rps_rsp_if.source                          rsp_chan,
   input  wire                                csr_write_enable,
   input  wire  [rps_pkg::COUNT_WIDTH-1:0]    csr_write_data
);
   import rps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SWAP1,
      ST_SWAP2,
      ST_READ0,
      ST_EMIT0
   } state_type;

   state_type              state_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   idx_type                cursor_ff;
   logic                   active_ff;
   logic                   rsp_valid_ff;
   idx_type                rsp_slot_ff;
   idx_type                rsp_value_ff;
   logic                   rsp_last_ff;

   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   div_start;
   logic                   div_done;
   idx_type                div_rem;
   logic [DIV_WIDTH-1:0]   divisor;
   logic [COUNT_WIDTH-1:0] count_sat;
   tbl_req_type            tbl_req;
   idx_type                rd_a;
   idx_type                rd_b;

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_valid_ff && rsp_chan.ready;

   assign divisor   = {1'b0, cursor_ff} + 1'b1;
   assign div_start = req_xfer && (req_chan.req_type == REQ_DRAW) && active_ff;

   always_comb begin
      if (count_ff == '0) begin
         count_sat = COUNT_WIDTH'(1);
      end else if (count_ff > COUNT_WIDTH'(TABLE_DEPTH)) begin
         count_sat = COUNT_WIDTH'(TABLE_DEPTH);
      end else begin
         count_sat = count_ff;
      end
   end

   rps_moddiv u_moddiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_chan.random_word),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      tbl_req           = '0;
      tbl_req.clear     = req_xfer && (req_chan.req_type == REQ_START);
      tbl_req.rd_addr_a = div_rem;
      tbl_req.rd_addr_b = cursor_ff;
      case (state_ff)
         ST_READ: begin
            tbl_req.rd_en = 1'b1;
         end
         ST_SWAP1: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = cursor_ff;
            tbl_req.wr_data = rd_a;
         end
         ST_SWAP2: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = div_rem;
            tbl_req.wr_data = rd_b;
         end
         ST_READ0: begin
            tbl_req.rd_en     = 1'b1;
            tbl_req.rd_addr_a = '0;
         end
         default: begin
         end
      endcase
   end

   rps_table u_table (
      .clock     (clock),
      .reset     (reset),
      .req       (tbl_req),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_slot_ff  <= '0;
         rsp_value_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_chan.req_type == REQ_START) begin
                     cursor_ff <= IDX_WIDTH'(count_sat - 1'b1);
                     if (count_sat == COUNT_WIDTH'(1)) begin
                        active_ff    <= 1'b0;
                        rsp_valid_ff <= 1'b1;
                        rsp_slot_ff  <= '0;
                        rsp_value_ff <= '0;
                        rsp_last_ff  <= 1'b1;
                     end else begin
                        active_ff <= 1'b1;
                     end
                  end else if (active_ff) begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_SWAP1;
            end
            ST_SWAP1: begin
               state_ff <= ST_SWAP2;
            end
            ST_SWAP2: begin
               // result register is empty here: draws are taken only when it is
               rsp_valid_ff <= 1'b1;
               rsp_slot_ff  <= cursor_ff;
               rsp_value_ff <= rd_a;
               rsp_last_ff  <= 1'b0;
               cursor_ff    <= cursor_ff - 1'b1;
               if (cursor_ff == IDX_WIDTH'(1)) begin
                  state_ff <= ST_READ0;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_READ0: begin
               state_ff <= ST_EMIT0;
            end
            ST_EMIT0: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff  <= '0;
                  rsp_value_ff <= rd_a;
                  rsp_last_ff  <= 1'b1;
                  active_ff    <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.slot  = rsp_slot_ff;
   assign rsp_chan.value = rsp_value_ff;
   assign rsp_chan.last  = rsp_last_ff;

endmodule
`default_nettype wire

>>> rtl/rps_moddiv.sv
// iterative remainder unit, two dividend bits per cycle
`default_nettype none
module rps_moddiv (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [rps_pkg::WORD_WIDTH-1:0] dividend,
   input  wire  [rps_pkg::DIV_WIDTH-1:0]  divisor,
   output logic                           done,
   output logic [rps_pkg::IDX_WIDTH-1:0]  remainder
);
   import rps_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [SHIFT_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [DIV_WIDTH-1:0]   rem_mid;

   assign rem_mid = mod_step(rem_ff, shift_ff[SHIFT_WIDTH-1], divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         shift_in   = {{(SHIFT_WIDTH-WORD_WIDTH){1'b0}}, dividend};
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = mod_step(rem_mid, shift_ff[SHIFT_WIDTH-2], divisor_ff);
         shift_in = {shift_ff[SHIFT_WIDTH-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_WIDTH'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_WIDTH-1:0];

endmodule
`default_nettype wire

>>> rtl/rps_table.sv
// permutation store: one write port, two registered read ports, per-entry valid bits
`default_nettype none
module rps_table (
   input  wire                          clock,
   input  wire                          reset,
   input  rps_pkg::tbl_req_type         req,
   output logic [rps_pkg::IDX_WIDTH-1:0] rd_data_a,
   output logic [rps_pkg::IDX_WIDTH-1:0] rd_data_b
);
   import rps_pkg::*;

   idx_type                perm_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   idx_type                rd_a_ff;
   idx_type                rd_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         perm_mem[req.wr_addr] <= req.wr_data;
      end
   end

   // an entry never written since start holds its own index
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_a_ff <= valid_ff[req.rd_addr_a] ? perm_mem[req.rd_addr_a] : req.rd_addr_a;
         rd_b_ff <= valid_ff[req.rd_addr_b] ? perm_mem[req.rd_addr_b] : req.rd_addr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the permutation shuffler: directed steps, then random shuffles
module testbench;
   import rps_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET   = 1600;
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = '1;

   typedef struct packed {
      idx_type slot;
      idx_type value;
      logic    last;
   } place_type;

   typedef struct packed {
      logic                   csr_row;
      logic [COUNT_WIDTH-1:0] csr_val;
      logic                   kind;
      logic [WORD_WIDTH-1:0]  word;
      logic                   typed;
      logic [1:0]             n;
      place_type              r0;
      place_type              r1;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [COUNT_WIDTH-1:0] csr_write_data;

   rps_req_if req_bus();
   rps_rsp_if rsp_bus();

   random_permutation_shuffler_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shuffle state as the block should hold it
   idx_type                perm_model [TABLE_DEPTH];
   idx_type                cursor_model;
   logic                   running_model;
   logic [COUNT_WIDTH-1:0] count_model;
   place_type              placements_due [$];

   int   error_count     = 0;
   int   items_done      = 0;
   int   starts_done     = 0;
   int   draws_done      = 0;
   int   ignored_draws   = 0;
   int   results_checked = 0;
   int   phases_done     = 0;
   int   idle_cycles     = 0;
   logic sender_quiet    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int clamp_count(input logic [COUNT_WIDTH-1:0] c);
      if (c < 1) return 1;
      if (c > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(c);
   endfunction

   // a start or one backward Fisher-Yates step; returns the number of placements it makes final
   function automatic int shuffle_step(input logic kind, input logic [WORD_WIDTH-1:0] word,
                                       output place_type [1:0] res);
      int          n;
      int          pos;
      int          j;
      idx_type     held;
      logic [31:0] wide;
      res = '0;
      if (kind == REQ_START) begin
         n = clamp_count(count_model);
         for (int i = 0; i < TABLE_DEPTH; i++) perm_model[i] = idx_type'(i);
         cursor_model = idx_type'(n - 1);
         if (n == 1) begin
            running_model = 1'b0;
            res[0] = '{slot: '0, value: perm_model[0], last: 1'b1};
            return 1;
         end
         running_model = 1'b1;
         return 0;
      end
      if (!running_model) return 0;
      pos  = int'(cursor_model);
      wide = {1'b0, word};
      j    = int'(wide % 32'(pos + 1));
      held            = perm_model[pos];
      perm_model[pos] = perm_model[j];
      perm_model[j]   = held;
      res[0] = '{slot: idx_type'(pos), value: perm_model[pos], last: 1'b0};
      pos--;
      cursor_model = idx_type'(pos);
      if (pos == 0) begin
         running_model = 1'b0;
         res[1] = '{slot: '0, value: perm_model[0], last: 1'b1};
         return 2;
      end
      return 1;
   endfunction

   function automatic place_type pl(input int s, input int v, input logic l);
      return '{slot: idx_type'(s), value: idx_type'(v), last: l};
   endfunction

   function automatic step_row_type xfer(input logic kind, input logic [WORD_WIDTH-1:0] word);
      step_row_type r;
      r      = '0;
      r.kind = kind;
      r.word = word;
      return r;
   endfunction

   function automatic step_row_type typed_xfer(input logic kind,
                                               input logic [WORD_WIDTH-1:0] word,
                                               input int n, input place_type r0,
                                               input place_type r1);
      step_row_type r;
      r       = xfer(kind, word);
      r.typed = 1'b1;
      r.n     = 2'(n);
      r.r0    = r0;
      r.r1    = r1;
      return r;
   endfunction

   function automatic step_row_type csr_step(input logic [COUNT_WIDTH-1:0] val);
      step_row_type r;
      r         = '0;
      r.csr_row = 1'b1;
      r.csr_val = val;
      return r;
   endfunction

   // valid stays high across back-to-back transfers; lowered only ahead of a gap or to settle
   task automatic send_item(input logic kind, input logic [WORD_WIDTH-1:0] word,
                            input logic typed, input int typed_n,
                            input place_type [1:0] typed_res);
      int              gap;
      int              n;
      int              k;
      place_type [1:0] res;
      gap = sender_quiet ? 0 : pick_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.random_word <= word;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == REQ_START) starts_done++;
      else if (running_model) draws_done++;
      else ignored_draws++;
      if (kind == REQ_START || running_model) items_done++;
      n = shuffle_step(kind, word, res);
      if (typed) begin
         n   = typed_n;
         res = typed_res;
      end
      for (k = 0; k < n; k++) placements_due.push_back(res[k]);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      // a draw with no result may still be in the divider
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_WIDTH-1:0] val);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_model = val;
   endtask

   always @(posedge clock) begin
      place_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (placements_due.size() == 0) begin
            flag_mismatch($sformatf("result with none pending: slot %0d value %0d last %0d",
                                    rsp_bus.slot, rsp_bus.value, rsp_bus.last));
         end else begin
            want = placements_due.pop_front();
            if (rsp_bus.slot !== want.slot)
               flag_mismatch($sformatf("slot %0d, want %0d", rsp_bus.slot, want.slot));
            if (rsp_bus.value !== want.value)
               flag_mismatch($sformatf("value %0d at slot %0d, want %0d",
                                       rsp_bus.value, want.slot, want.value));
            if (rsp_bus.last !== want.last)
               flag_mismatch($sformatf("last %0d at slot %0d, want %0d",
                                       rsp_bus.last, want.slot, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles, %0d results pending",
                  IDLE_LIMIT, placements_due.size());
         $display("[random_permutation_shuffler_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure, in stretches that are each calm or stalling at random
   initial begin : rsp_stall
      int   stretch;
      int   hold_low;
      logic calm;
      hold_low = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         calm    = ($urandom_range(3) == 0);
         stretch = $urandom_range(50, 400);
         while (stretch > 0) begin
            @(posedge clock);
            stretch--;
            if (hold_low > 0) begin
               rsp_bus.ready <= 1'b0;
               hold_low--;
            end else begin
               rsp_bus.ready <= 1'b1;
               if (!calm) hold_low = pick_len();
            end
         end
      end
   end

   initial begin : stimulus
      step_row_type           directed_steps [$];
      step_row_type           row;
      int                     eff;
      int                     shuffles;
      int                     draws_left;
      logic [COUNT_WIDTH-1:0] pick;

      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.req_type    <= REQ_START;
      req_bus.random_word <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) perm_model[i] = idx_type'(i);
      cursor_model  = '0;
      running_model = 1'b0;
      count_model   = COUNT_RESET;

      // draw before any start, then a full-size start on the reset count
      directed_steps.push_back(typed_xfer(REQ_DRAW, WORD_MAX, 0, '0, '0));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, WORD_MAX, 1, pl(63, 63, 0), '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, '0, 1, pl(62, 0, 0), '0));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h2AAAAAAA));
      // count changed mid-shuffle: the running shuffle keeps its size
      directed_steps.push_back(csr_step(7'd1));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h55555555));
      directed_steps.push_back(typed_xfer(REQ_START, WORD_MAX, 1, pl(0, 0, 1), '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, 31'h1234, 0, '0, '0));
      // zero count behaves as one
      directed_steps.push_back(csr_step(7'd0));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 1, pl(0, 0, 1), '0));
      directed_steps.push_back(csr_step(7'd2));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, WORD_MAX, 2, pl(1, 1, 0), pl(0, 0, 1)));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, '0, 2, pl(1, 0, 0), pl(0, 1, 1)));
      // counts above the table depth saturate
      directed_steps.push_back(csr_step('1));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(typed_xfer(REQ_DRAW, WORD_MAX, 1, pl(63, 63, 0), '0));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h6B8B4567));
      // restart abandons the running shuffle
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h7FFFFFFE));
      directed_steps.push_back(csr_step(7'd64));
      directed_steps.push_back(csr_step(7'd3));
      directed_steps.push_back(typed_xfer(REQ_START, '0, 0, '0, '0));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h3));
      directed_steps.push_back(xfer(REQ_DRAW, 31'h40000000));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.csr_row) write_count(row.csr_val);
         else send_item(row.kind, row.word, row.typed, row.n, {row.r1, row.r0});
      end

      while (items_done < ITEM_TARGET) begin
         case ($urandom_range(19))
            0:       pick = '0;
            1:       pick = COUNT_WIDTH'($urandom_range(TABLE_DEPTH + 1, (1 << COUNT_WIDTH) - 1));
            2, 3:    pick = COUNT_WIDTH'($urandom_range(33, TABLE_DEPTH));
            4, 5, 6: pick = COUNT_WIDTH'($urandom_range(9, 32));
            default: pick = COUNT_WIDTH'($urandom_range(1, 8));
         endcase
         write_count(pick);
         sender_quiet = ($urandom_range(3) == 0);
         phases_done++;
         // sometimes finish a shuffle begun under the previous count
         if (running_model && $urandom_range(1) == 1) begin
            draws_left = int'(cursor_model);
            repeat (draws_left) send_item(REQ_DRAW, WORD_WIDTH'($urandom), 1'b0, 0, '0);
         end
         shuffles = $urandom_range(1, 4);
         repeat (shuffles) begin
            eff = clamp_count(count_model);
            send_item(REQ_START, WORD_WIDTH'($urandom), 1'b0, 0, '0);
            draws_left = eff - 1;
            if ($urandom_range(9) == 0) begin
               draws_left = $urandom_range(draws_left);
            end else if ($urandom_range(19) == 0) begin
               draws_left += $urandom_range(1, 3);
            end
            repeat (draws_left) send_item(REQ_DRAW, WORD_WIDTH'($urandom), 1'b0, 0, '0);
         end
      end

      settle();
      $display("covered %0d starts and %0d draws (%0d more while idle), %0d results checked",
               starts_done, draws_done, ignored_draws, results_checked);
      $display("%0d random count phases, %0d failures", phases_done, error_count);
      if (error_count == 0) begin
         $display("[random_permutation_shuffler_top] OK");
      end else begin
         $display("[random_permutation_shuffler_top] ERROR");
      end
      $finish;
   end

endmodule
